/* design/i4x4_pkg.sv */
package i4x4_pkg;

  localparam int SampleW = 14;
  localparam int ResW    = 16;
  localparam int SumW    = 18;

  typedef enum logic [3:0] {
    MODE_V   = 4'd0,
    MODE_H   = 4'd1,
    MODE_DC  = 4'd2,
    MODE_DDL = 4'd3,
    MODE_DDR = 4'd4,
    MODE_VR  = 4'd5,
    MODE_HD  = 4'd6,
    MODE_VL  = 4'd7,
    MODE_HU  = 4'd8
  } mode_t;

  typedef struct packed {
    logic [63:0] residual_row3;
    logic [63:0] residual_row2;
    logic [63:0] residual_row1;
    logic [63:0] residual_row0;
    logic [3:0]  neighbour_avail;
    logic [13:0] corner_sample;
    logic [55:0] left_column;
    logic [55:0] top_right_row;
    logic [55:0] top_row;
    logic [3:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic        mode_error;
    logic [55:0] recon_row3;
    logic [55:0] recon_row2;
    logic [55:0] recon_row1;
    logic [55:0] recon_row0;
  } out_item_t;

  // edge samples: e[0..3] left y=3..0, e[4] corner, e[5..12] top x=0..7
  typedef logic [SampleW-1:0] edge_arr_t [13];

  typedef struct packed {
    logic [3:0]        mode;
    logic [SampleW-1:0] dc;
  } lane_ctl_t;

  function automatic logic [SampleW-1:0] tap3(input logic [SampleW-1:0] a,
                                              input logic [SampleW-1:0] b,
                                              input logic [SampleW-1:0] c);
    logic [SampleW+1:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + (SampleW+2)'(2);
    return s[SampleW+1:2];
  endfunction

  function automatic logic [SampleW-1:0] tap2(input logic [SampleW-1:0] a,
                                              input logic [SampleW-1:0] b);
    logic [SampleW:0] s;
    s = {1'b0, a} + {1'b0, b} + (SampleW+1)'(1);
    return s[SampleW:1];
  endfunction

endpackage

/* design/i4x4_lane.sv */
module i4x4_lane
  import i4x4_pkg::*;
#(
  parameter int X = 0,
  parameter int Y = 0
) (
  input  edge_arr_t            e,
  input  lane_ctl_t            ctl,
  input  logic [ResW-1:0]      res,
  input  logic [SampleW-1:0]   maxv,
  output logic [SampleW-1:0]   recon
);

  localparam int Zv = 2*X - Y;
  localparam int Zh = 2*Y - X;
  localparam int Zu = X + 2*Y;

  // p[x,-1] -> e[5+x] (x=-1 is corner e[4]); p[-1,y] -> e[3-y]
  function automatic logic [SampleW-1:0] pt(input edge_arr_t a, input int x);
    return a[5+x];
  endfunction
  function automatic logic [SampleW-1:0] pl(input edge_arr_t a, input int y);
    return a[3-y];
  endfunction

  logic [SampleW-1:0] pred;
  logic signed [SumW-1:0] v;

  always_comb begin
    case (ctl.mode)
      MODE_V:  pred = pt(e, X);
      MODE_H:  pred = pl(e, Y);
      MODE_DC: pred = ctl.dc;
      MODE_DDL: begin
        if (X == 3 && Y == 3) pred = tap3(pt(e, 6), pt(e, 7), pt(e, 7));
        else pred = tap3(pt(e, X+Y), pt(e, X+Y+1), pt(e, X+Y+2));
      end
      MODE_DDR: begin
        if (X > Y) pred = tap3(pt(e, X-Y-2), pt(e, X-Y-1), pt(e, X-Y));
        else if (X < Y) pred = tap3(pl(e, Y-X-2), pl(e, Y-X-1), pl(e, Y-X));
        else pred = tap3(pt(e, 0), pt(e, -1), pl(e, 0));
      end
      MODE_VR: begin
        if (Zv >= 0 && Zv % 2 == 0) pred = tap2(pt(e, X-Y/2-1), pt(e, X-Y/2));
        else if (Zv > 0) pred = tap3(pt(e, X-Y/2-2), pt(e, X-Y/2-1), pt(e, X-Y/2));
        else if (Zv == -1) pred = tap3(pl(e, 0), pl(e, -1), pt(e, 0));
        else pred = tap3(pl(e, Y-1), pl(e, Y-2), pl(e, Y-3));
      end
      MODE_HD: begin
        if (Zh >= 0 && Zh % 2 == 0) pred = tap2(pl(e, Y-X/2-1), pl(e, Y-X/2));
        else if (Zh > 0) pred = tap3(pl(e, Y-X/2-2), pl(e, Y-X/2-1), pl(e, Y-X/2));
        else if (Zh == -1) pred = tap3(pl(e, 0), pl(e, -1), pt(e, 0));
        else pred = tap3(pt(e, X-1), pt(e, X-2), pt(e, X-3));
      end
      MODE_VL: begin
        if (Y % 2 == 0) pred = tap2(pt(e, X+Y/2), pt(e, X+Y/2+1));
        else pred = tap3(pt(e, X+Y/2), pt(e, X+Y/2+1), pt(e, X+Y/2+2));
      end
      MODE_HU: begin
        if (Zu == 0 || Zu == 2 || Zu == 4)
          pred = tap2(pl(e, Y+X/2), pl(e, Y+X/2+1));
        else if (Zu == 1 || Zu == 3)
          pred = tap3(pl(e, Y+X/2), pl(e, Y+X/2+1), pl(e, Y+X/2+2));
        else if (Zu == 5) pred = tap3(pl(e, 2), pl(e, 3), pl(e, 3));
        else pred = pl(e, 3);
      end
      default: pred = '0;
    endcase
  end

  always_comb begin
    v = $signed({{(SumW-SampleW){1'b0}}, pred}) + SumW'($signed(res));
    if (v < 0) recon = '0;
    else if (v > $signed({{(SumW-SampleW){1'b0}}, maxv})) recon = maxv;
    else recon = v[SampleW-1:0];
  end

endmodule

/* design/i4x4_merge.sv */
module i4x4_merge
  import i4x4_pkg::*;
(
  input  logic [SampleW-1:0] recon [16],
  input  logic               err,
  output out_item_t          item
);

  logic [55:0] rows [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        rows[r][c*SampleW +: SampleW] = err ? '0 : recon[r*4+c];
      end
    end
    item.recon_row0 = rows[0];
    item.recon_row1 = rows[1];
    item.recon_row2 = rows[2];
    item.recon_row3 = rows[3];
    item.mode_error = err;
  end

endmodule

/* design/intra_4x4_luma_predict_reconstruct.sv */
// H.264 intra 4x4 luma prediction and reconstruction. One 4x4 block per item,
// one item per cycle unless in_stall is high: the first register stage forms
// edge samples, DC and error, sixteen lanes then predict, add residual and clip,
// and the result lands in an output register with a skid stage so input is taken
// while a result waits. The user writes bit depth via cfg_wr_en while idle; the
// block does not enforce it. Values outside 8..14 are clamped. A failing mode or
// missing neighbour zeroes the block and sets mode_error.
module intra_4x4_luma_predict_reconstruct
  import i4x4_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic [3:0] bd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) bd_r <= 4'd8;
    else if (cfg_wr_en) bd_r <= cfg_wr_data;
  end

  logic [3:0] bd;
  assign bd = (bd_r < 4'd8) ? 4'd8 : (bd_r > 4'd14) ? 4'd14 : bd_r;

  // stage 1
  logic       s1_v_r;
  edge_arr_t  e_r;
  lane_ctl_t  ctl_r;
  logic       err_r;
  logic [63:0] res_r [4];
  logic [SampleW-1:0] maxv_r;

  // output + skid
  logic      o_v_r, sk_v_r;
  out_item_t o_r, sk_r;

  logic adv;
  assign adv = !sk_v_r;
  assign in_stall = sk_v_r;

  edge_arr_t e_nxt;
  lane_ctl_t ctl_nxt;
  logic      err_nxt;
  logic      ht, hl, htr, hc;
  logic [SampleW+2:0] s_t, s_l;
  logic [SampleW+3:0] s_a;

  always_comb begin
    ht  = in_item.neighbour_avail[0];
    hl  = in_item.neighbour_avail[1];
    htr = in_item.neighbour_avail[2];
    hc  = in_item.neighbour_avail[3];
    for (int i = 0; i < 4; i++) begin
      e_nxt[3-i] = in_item.left_column[i*SampleW +: SampleW];
      e_nxt[5+i] = in_item.top_row[i*SampleW +: SampleW];
      e_nxt[9+i] = htr ? in_item.top_right_row[i*SampleW +: SampleW]
                       : in_item.top_row[3*SampleW +: SampleW];
    end
    e_nxt[4] = in_item.corner_sample;
    s_t = '0;
    s_l = '0;
    for (int i = 0; i < 4; i++) begin
      s_t = s_t + (SampleW+3)'(in_item.top_row[i*SampleW +: SampleW]);
      s_l = s_l + (SampleW+3)'(in_item.left_column[i*SampleW +: SampleW]);
    end
    s_a = (SampleW+4)'(s_t) + (SampleW+4)'(s_l) + (SampleW+4)'(4);
    ctl_nxt.mode = in_item.mode;
    if (ht && hl) ctl_nxt.dc = s_a[SampleW+2:3];
    else if (ht) ctl_nxt.dc = SampleW'((s_t + (SampleW+3)'(2)) >> 2);
    else if (hl) ctl_nxt.dc = SampleW'((s_l + (SampleW+3)'(2)) >> 2);
    else ctl_nxt.dc = SampleW'(1) << (bd - 4'd1);
    case (in_item.mode)
      MODE_V, MODE_DDL, MODE_VL:  err_nxt = !ht;
      MODE_H, MODE_HU:            err_nxt = !hl;
      MODE_DC:                    err_nxt = 1'b0;
      MODE_DDR, MODE_VR, MODE_HD: err_nxt = !(ht && hl && hc);
      default:                    err_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
    if (adv && in_valid) begin
      e_r    <= e_nxt;
      ctl_r  <= ctl_nxt;
      err_r  <= err_nxt;
      res_r[0] <= in_item.residual_row0;
      res_r[1] <= in_item.residual_row1;
      res_r[2] <= in_item.residual_row2;
      res_r[3] <= in_item.residual_row3;
      maxv_r <= SampleW'((15'd1 << bd) - 15'd1);
    end
  end

  logic [SampleW-1:0] recon [16];

  for (genvar gy = 0; gy < 4; gy++) begin : g_row
    for (genvar gx = 0; gx < 4; gx++) begin : g_col
      i4x4_lane #(.X(gx), .Y(gy)) u_lane (
        .e    (e_r),
        .ctl  (ctl_r),
        .res  (res_r[gy][gx*ResW +: ResW]),
        .maxv (maxv_r),
        .recon(recon[gy*4+gx])
      );
    end
  end

  out_item_t merged;
  i4x4_merge u_merge (.recon(recon), .err(err_r), .item(merged));

  // output register with skid
  logic o_busy;
  assign o_busy = o_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      if (!o_busy) begin
        if (sk_v_r) begin
          o_v_r  <= 1'b1;
          sk_v_r <= 1'b0;
        end else begin
          o_v_r <= s1_v_r;
        end
      end else if (s1_v_r && !sk_v_r) begin
        sk_v_r <= 1'b1;
      end
    end
    if (!o_busy) begin
      if (sk_v_r) o_r <= sk_r;
      else if (s1_v_r) o_r <= merged;
    end else if (s1_v_r && !sk_v_r) begin
      sk_r <= merged;
    end
  end

  assign out_valid = o_v_r;
  assign out_item  = o_r;

endmodule

/* design/i4x4_checker.sv */
module i4x4_checker
  import i4x4_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.mode_error |->
      out_item.recon_row0 == '0 && out_item.recon_row1 == '0 &&
      out_item.recon_row2 == '0 && out_item.recon_row3 == '0)
    else $error("error item carries samples");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("item lost");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without back-pressure");

endmodule

bind intra_4x4_luma_predict_reconstruct i4x4_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
